>>> sv/deque_with_delete_by_key_assert.svh
// Assertion macros used by the deque-with-delete-by-key top level.
`ifndef DEQUE_WITH_DELETE_BY_KEY_ASSERT_SVH
`define DEQUE_WITH_DELETE_BY_KEY_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DQK_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DQK_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dqk_pkg.sv
// Package: sizes, request/status codes, command type and key helpers for the deque.
`timescale 1ns / 1ps
package dqk_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QFILL_W  = $clog2(QDEPTH + 1);

  // Request codes on the input channel
  localparam logic [2:0] REQ_INSERT    = 3'd0;
  localparam logic [2:0] REQ_DEL_KEY   = 3'd1;
  localparam logic [2:0] REQ_DEL_FIRST = 3'd2;
  localparam logic [2:0] REQ_DEL_LAST  = 3'd3;
  localparam logic [2:0] REQ_DUMP      = 3'd4;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_DEL_KEY,
    OP_DEL_FIRST,
    OP_DEL_LAST,
    OP_DUMP,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_BITS-1:0] key;
  } cmd_t;

  // Sign-extend or truncate an input key to the stored key width
  function automatic logic [KEY_BITS-1:0] key_in(input logic signed [31:0] k);
    return KEY_BITS'(k);
  endfunction

  // Stored key to output element: low 32 bits, zero-filled when narrower
  function automatic logic [31:0] key_out(input logic [KEY_BITS-1:0] k);
    return 32'(k);
  endfunction

endpackage

>>> sv/dqk_front.sv
// Front end: accepts requests, decodes them into commands, buffers them in a short queue.
`timescale 1ns / 1ps
module dqk_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_key,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output dqk_pkg::cmd_t      cmd
);
  import dqk_pkg::*;

  cmd_t               q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QFILL_W-1:0] fill_r;
  logic [QFILL_W-1:0] fill_nxt;
  cmd_t               dec;
  logic               push;
  logic               pop;

  // Classify the request
  always_comb begin
    dec.key = key_in(in_key);
    unique case (in_req_type)
      REQ_INSERT:    dec.op = OP_INSERT;
      REQ_DEL_KEY:   dec.op = OP_DEL_KEY;
      REQ_DEL_FIRST: dec.op = OP_DEL_FIRST;
      REQ_DEL_LAST:  dec.op = OP_DEL_LAST;
      REQ_DUMP:      dec.op = OP_DUMP;
      default:       dec.op = OP_NOP;
    endcase
  end

  assign in_ready  = (fill_r != QFILL_W'(QDEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

>>> sv/dqk_back.sv
// Back end: circular entry memory, command sequencer (scan, compact, dump) and result register.
`timescale 1ns / 1ps
module dqk_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  dqk_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_element,
  output logic               out_element_valid,
  output logic               out_last_item,
  output logic [1:0]         out_status,
  output logic [6:0]         out_occupancy
);
  import dqk_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_DUMP   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  // Logical position to physical address, front at head
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [KEY_BITS-1:0] mem_r [CAPACITY];
  logic [KEY_BITS-1:0] rdata_r;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    j_r, j_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  status_t             status_r, status_nxt;

  logic                rd_en;
  logic [CNT_W-1:0]    rd_off;
  logic                we;
  logic [IDX_W-1:0]    wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  logic                emit;
  logic [31:0]         emit_elem;
  logic                emit_ev;
  logic                emit_last;
  status_t             emit_status;

  logic                out_valid_r;
  logic [31:0]         out_elem_r;
  logic                out_ev_r;
  logic                out_last_r;
  status_t             out_status_r;
  logic [CNT_W-1:0]    out_occ_r;

  logic                can_emit;
  logic [CNT_W-1:0]    j_ext;
  logic                j_last;
  logic                is_empty;
  logic [IDX_W-1:0]    head_dec;
  logic [IDX_W-1:0]    head_inc;

  assign can_emit  = !out_valid_r || out_ready;
  assign j_ext     = CNT_W'(j_r);
  assign j_last    = (j_ext + 1'b1 == count_r);
  assign is_empty  = (count_r == '0);
  assign head_dec  = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - 1'b1;
  assign head_inc  = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
  assign cmd_ready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    j_nxt       = j_r;
    key_nxt     = key_r;
    status_nxt  = status_r;
    rd_en       = 1'b0;
    rd_off      = '0;
    we          = 1'b0;
    wr_addr     = head_dec;
    wr_data     = cmd.key;
    emit        = 1'b0;
    emit_elem   = '0;
    emit_ev     = 1'b0;
    emit_last   = 1'b1;
    emit_status = status_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          key_nxt    = cmd.key;
          status_nxt = ST_OK;
          j_nxt      = '0;
          state_nxt  = S_FINISH;
          unique case (cmd.op)
            OP_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                we        = 1'b1;
                head_nxt  = head_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_DEL_KEY: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            OP_DEL_FIRST: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                head_nxt  = head_inc;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_DEL_LAST: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            OP_DUMP: begin
              if (!is_empty) begin
                rd_en     = 1'b1;
                state_nxt = S_DUMP;
              end
            end
            OP_NOP: begin
              state_nxt = S_FINISH;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end

      // rdata_r holds entry j; one compare per cycle
      S_SCAN: begin
        if (rdata_r == key_r) begin
          if (j_last) begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_FINISH;
          end else begin
            rd_en     = 1'b1;
            rd_off    = j_ext + 1'b1;
            state_nxt = S_SHIFT;
          end
        end else if (j_last) begin
          status_nxt = ST_ABSENT;
          state_nxt  = S_FINISH;
        end else begin
          rd_en  = 1'b1;
          rd_off = j_ext + 1'b1;
          j_nxt  = j_r + 1'b1;
        end
      end

      // rdata_r holds entry j+1; move it down to j
      S_SHIFT: begin
        we      = 1'b1;
        wr_addr = phys(head_r, j_ext);
        wr_data = rdata_r;
        if (CNT_W'(j_ext + 2'd2) < count_r) begin
          rd_en  = 1'b1;
          rd_off = j_ext + 2'd2;
          j_nxt  = j_r + 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_FINISH;
        end
      end

      // rdata_r holds entry j; held while the result register is stalled
      S_DUMP: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_elem   = key_out(rdata_r);
          emit_ev     = 1'b1;
          emit_last   = j_last;
          emit_status = ST_OK;
          if (j_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en  = 1'b1;
            rd_off = j_ext + 1'b1;
            j_nxt  = j_r + 1'b1;
          end
        end
      end

      S_FINISH: begin
        if (can_emit) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[phys(head_nxt, rd_off)];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      j_r      <= '0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      j_r      <= j_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_elem_r   <= emit_elem;
      out_ev_r     <= emit_ev;
      out_last_r   <= emit_last;
      out_status_r <= emit_status;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_element       = out_elem_r;
  assign out_element_valid = out_ev_r;
  assign out_last_item     = out_last_r;
  assign out_status        = out_status_r;
  assign out_occupancy     = 7'(out_occ_r);

endmodule

>>> sv/deque_with_delete_by_key.sv
// Top level: ordered key list with front insert, end pops, delete by key and dump.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   in       | in_valid / in_ready  | in_req_type, in_key
//   out      | out_valid / out_ready| out_element, out_element_valid, out_last_item,
//            |                      | out_status, out_occupancy
//
// Insert, pops, dump of an empty list and unknown requests give one result each.
// Delete by key scans one entry per cycle on the memory read port, then compacts
// one entry per cycle. Dump streams one element per cycle while the output is
// not stalled.
// A two-item command queue lets requests be taken while the back end works.
// Reset (synchronous, active low) empties the list at once; no clearing pass.
`timescale 1ns / 1ps
`include "deque_with_delete_by_key_assert.svh"
module deque_with_delete_by_key (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_element,
  output logic               out_element_valid,
  output logic               out_last_item,
  output logic [1:0]         out_status,
  output logic [6:0]         out_occupancy
);
  import dqk_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  dqk_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  dqk_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd               (cmd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_element       (out_element),
    .out_element_valid (out_element_valid),
    .out_last_item     (out_last_item),
    .out_status        (out_status),
    .out_occupancy     (out_occupancy)
  );

  // Checks
  `DQK_ASSERT_IMPL(a_occ_bound, clk, rst_n, out_valid, out_occupancy <= 7'(CAPACITY), "occupancy above capacity")
  `DQK_ASSERT_IMPL(a_elem_ok, clk, rst_n, out_valid && out_element_valid, out_status == ST_OK, "element with error status")
  `DQK_ASSERT_IMPL(a_single_last, clk, rst_n, out_valid && !out_element_valid, out_last_item, "single result not marked last")
  `DQK_ASSERT_NEXT(a_dump_occ, clk, rst_n, out_valid && out_ready && out_element_valid && !out_last_item, out_occupancy == $past(out_occupancy), "occupancy moved during dump")

endmodule

>>> test/tb_top.sv
// Testbench for deque_with_delete_by_key: random and directed list requests checked against a predicted list.
`timescale 1ns / 1ps
module tb_top;
  import dqk_pkg::*;

  // Request codes the block does not use; they must still answer once
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  typedef struct {
    logic [31:0] element;
    logic        element_valid;
    logic        last_item;
    status_t     status;
    logic [6:0]  occupancy;
  } list_result_t;

  // Predicted list contents plus the results still owed by the block
  class dqk_scoreboard;
    logic [31:0]  entries[$];       // front at index 0
    list_result_t owed[$];
    int errors;
    int checked;
    int dumped;
    int full_hits;
    int empty_hits;
    int absent_hits;

    function void report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function void owe(logic [31:0] elem, logic valid, logic last, status_t st);
      list_result_t r;
      r.element       = elem;
      r.element_valid = valid;
      r.last_item     = last;
      r.status        = st;
      r.occupancy     = 7'(entries.size());
      owed.insert(owed.size(), r);
    endfunction

    // Apply one accepted request to the predicted list
    function void note_request(logic [2:0] req, logic [31:0] key);
      status_t st;
      bit      found;
      st = ST_OK;
      found = 1'b0;
      case (req)
        REQ_INSERT: begin
          if (entries.size() >= CAPACITY) st = ST_FULL;
          else entries.insert(0, key);
        end
        REQ_DEL_KEY: begin
          if (entries.size() == 0) st = ST_EMPTY;
          else begin
            for (int i = 0; i < entries.size() && !found; i++) begin
              if (entries[i] == key) begin
                entries.delete(i);
                found = 1'b1;
              end
            end
            if (!found) st = ST_ABSENT;
          end
        end
        REQ_DEL_FIRST: begin
          if (entries.size() == 0) st = ST_EMPTY;
          else entries.delete(0);
        end
        REQ_DEL_LAST: begin
          if (entries.size() == 0) st = ST_EMPTY;
          else entries.delete(entries.size() - 1);
        end
        REQ_DUMP: begin
          // non-empty dump: one result per entry, last one marked
          if (entries.size() > 0) begin
            for (int i = 0; i < entries.size(); i++)
              owe(entries[i], 1'b1, i == entries.size() - 1, ST_OK);
            return;
          end
        end
        default: ;
      endcase
      if (st == ST_FULL) full_hits++;
      if (st == ST_EMPTY) empty_hits++;
      if (st == ST_ABSENT) absent_hits++;
      owe(32'd0, 1'b0, 1'b1, st);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      checked++;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected result element=%h status=%0d",
                                  got.element, got.status));
        return;
      end
      want = owed[0];
      owed.delete(0);
      if (got.element_valid === 1'b1) dumped++;
      if (got.element !== want.element)
        report_mismatch($sformatf("element %h, want %h", got.element, want.element));
      if (got.element_valid !== want.element_valid)
        report_mismatch($sformatf("element_valid %b, want %b",
                                  got.element_valid, want.element_valid));
      if (got.last_item !== want.last_item)
        report_mismatch($sformatf("last_item %b, want %b", got.last_item, want.last_item));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.occupancy !== want.occupancy)
        report_mismatch($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_req_type = REQ_DUMP;
  logic signed [31:0] in_key = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_element;
  logic               out_element_valid;
  logic               out_last_item;
  logic [1:0]         out_status;
  logic [6:0]         out_occupancy;

  dqk_scoreboard sb = new;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int stall_left = 0;
  int sent = 0;

  deque_with_delete_by_key dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_element       (out_element),
    .out_element_valid (out_element_valid),
    .out_last_item     (out_last_item),
    .out_status        (out_status),
    .out_occupancy     (out_occupancy)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Keys: a small pool for duplicates and hits, otherwise any 32-bit value
  function automatic logic [31:0] pick_key();
    int idx;
    if ($urandom_range(0, 99) >= 40) return $urandom;
    idx = $urandom_range(0, 9);
    if (idx < 7) return 32'(idx);
    if (idx == 7) return 32'hFFFF_FFFF;
    if (idx == 8) return 32'h8000_0000;
    return 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] pick_delete_key();
    if (sb.entries.size() > 0 && $urandom_range(0, 99) < 70)
      return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
    return pick_key();
  endfunction

  // Present one item and hold it until the block takes it
  task automatic send_request(input logic [2:0] req, input logic [31:0] key);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_req_type <= 3'($urandom);
      in_key <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_key <= key;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, key);
    sent++;
    if ($urandom_range(0, 99) < 3) in_calm = !in_calm;
  endtask

  // One random request; weights in percent, remainder goes to unused codes
  task automatic random_request(input int w_ins, input int w_del, input int w_pop,
                                input int w_dump);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_ins)
      send_request(REQ_INSERT, pick_key());
    else if (r < w_ins + w_del)
      send_request(REQ_DEL_KEY, pick_delete_key());
    else if (r < w_ins + w_del + w_pop)
      send_request($urandom_range(0, 1) ? REQ_DEL_FIRST : REQ_DEL_LAST, $urandom);
    else if (r < w_ins + w_del + w_pop + w_dump)
      send_request(REQ_DUMP, $urandom);
    else
      send_request(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), $urandom);
  endtask

  // Result side back-pressure
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) out_calm = !out_calm;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!out_calm) stall_left = pick_gap();
    end
  end

  // Result monitor
  always @(posedge clk) begin
    list_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.element       = out_element;
      got.element_valid = out_element_valid;
      got.last_item     = out_last_item;
      got.status        = status_t'(out_status);
      got.occupancy     = out_occupancy;
      sb.check_result(got);
    end
  end

  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list cases and unused codes
    send_request(REQ_DUMP, 32'd0);
    send_request(REQ_DEL_FIRST, 32'd0);
    send_request(REQ_DEL_LAST, 32'd0);
    send_request(REQ_DEL_KEY, 32'd5);
    for (int c = REQ_UNUSED_LO; c <= REQ_UNUSED_HI; c++)
      send_request(3'(c), 32'hA5A5_5A5A);
    // extremes and a duplicate key
    send_request(REQ_INSERT, 32'd5);
    send_request(REQ_INSERT, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 32'h8000_0000);
    send_request(REQ_INSERT, 32'd5);
    send_request(REQ_INSERT, 32'd0);
    send_request(REQ_INSERT, 32'hFFFF_FFFF);
    send_request(REQ_DUMP, 32'd0);
    // first occurrence of 5 is mid-list; then a middle entry; then absent key
    send_request(REQ_DEL_KEY, 32'd5);
    send_request(REQ_DEL_KEY, 32'h7FFF_FFFF);
    send_request(REQ_DEL_KEY, 32'd12345);
    send_request(REQ_DUMP, 32'd0);
    send_request(REQ_DEL_FIRST, 32'd0);
    send_request(REQ_DEL_LAST, 32'd0);
    send_request(REQ_UNUSED_HI, 32'd0);
    send_request(REQ_DUMP, 32'd0);

    // Fill to capacity, then hit the full list
    while (sb.entries.size() < CAPACITY) random_request(94, 3, 1, 1);
    repeat (3) send_request(REQ_INSERT, pick_key());
    send_request(REQ_DUMP, 32'd0);
    send_request(REQ_DEL_KEY, pick_delete_key());
    send_request(REQ_INSERT, pick_key());
    send_request(REQ_INSERT, pick_key());

    // Mixed traffic, then mostly removals
    repeat (8) random_request(30, 25, 20, 10);
    repeat (24) random_request(3, 45, 45, 3);
    send_request(REQ_DEL_FIRST, $urandom);
    send_request(REQ_DEL_LAST, $urandom);
    send_request(REQ_DEL_KEY, pick_key());
    send_request(REQ_DUMP, $urandom);
    in_valid <= 1'b0;

    // Let the last results drain, then allow a full scan's worth of cycles
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 8) @(posedge clk);

    $display("Sent %0d requests, checked %0d results (%0d dumped entries).",
             sent, sb.checked, sb.dumped);
    $display("Status hits: full %0d, empty %0d, key absent %0d; mismatches %0d.",
             sb.full_hits, sb.empty_hits, sb.absent_hits, sb.errors);
    if (sb.errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/dqk_pkg.sv
sv/dqk_front.sv
sv/dqk_back.sv
sv/deque_with_delete_by_key.sv
test/tb_top.sv
